@@ rtl/core/led_matrix_time_renderer_assert.svh @@
// ----------------------------------------------------------------------------
// LED matrix time renderer assertion macros
// Concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_TIME_RENDERER_ASSERT_SVH
`define LED_MATRIX_TIME_RENDERER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LMTR_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("led matrix renderer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMTR_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("led matrix renderer assertion failed");

`else

`define LMTR_ASSERT_NOW(label, clk, rstn, pre, post)
`define LMTR_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

@@ rtl/core/lmtr_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix time renderer package
// Shared widths, word indexes and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtr_pkg;

    localparam int unsigned BCD_W      = 24;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned BRIGHT_W   = 4;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Word index: init words occupy 0..15, row words 16..47.
    localparam logic [IDX_W-1:0] FIRST_IDX = 6'd0;
    localparam logic [IDX_W-1:0] ROW_START = 6'd16;
    localparam logic [IDX_W-1:0] LAST_IDX  = 6'd47;

    // Register index of the brightness register.
    localparam logic REG_BRIGHTNESS = 1'b0;

    // Request for one output word.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [IDX_W-1:0] idx;
    } word_req_t;

    // One rendered output word with its markers.
    typedef struct packed {
        logic [WORD_W-1:0] spi_word;
        logic              latch;
        logic              last;
    } word_res_t;

endpackage

`default_nettype wire

@@ rtl/core/lmtr_cfg.sv @@
// ----------------------------------------------------------------------------
// LED matrix time renderer configuration registers
// APB-style register port holding the display brightness.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtr_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lmtr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [lmtr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [lmtr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [lmtr_pkg::BRIGHT_W-1:0]     brightness
);
    import lmtr_pkg::*;

    logic [BRIGHT_W-1:0] bright_reg;
    logic [BRIGHT_W-1:0] bright_next;
    logic                wr_en;
    logic                sel_bright;

    // The port never inserts wait states.
    assign pready     = 1'b1;
    assign sel_bright = (paddr[CFG_ADDR_W-1] == REG_BRIGHTNESS);
    assign wr_en      = psel && penable && pwrite && pready;

    // Only the low four bits of the written value are kept.
    always_comb begin
        bright_next = bright_reg;
        if (wr_en && sel_bright) begin
            bright_next = pwdata[BRIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= 4'd7;
        end else begin
            bright_reg <= bright_next;
        end
    end

    // Read data; addresses 4..7 read as zero, addresses 0..3 all return the brightness register.
    assign prdata     = sel_bright ? {{(CFG_DATA_W-BRIGHT_W){1'b0}}, bright_reg}
                                   : '0;
    assign brightness = bright_reg;

endmodule

`default_nettype wire

@@ rtl/core/lmtr_word_gen.sv @@
// ----------------------------------------------------------------------------
// LED matrix time renderer word generator
// Renders one pixel row from the BCD time and selects the requested word.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtr_word_gen (
    input  wire lmtr_pkg::word_req_t               req,
    input  wire logic [lmtr_pkg::BRIGHT_W-1:0]     brightness,
    output lmtr_pkg::word_res_t                    res
);
    import lmtr_pkg::*;

    // Init command words.
    localparam logic [WORD_W-1:0] CMD_SHUTDOWN = 16'h0C01;
    localparam logic [WORD_W-1:0] CMD_DECODE   = 16'h0900;
    localparam logic [WORD_W-1:0] CMD_SCANLIM  = 16'h0B07;
    localparam logic [WORD_W-1:0] CMD_INTENS   = 16'h0A00;

    localparam int unsigned COLON = 10;
    localparam int unsigned DOT   = 11;

    // Font: ten digits, then the colon and the dot, eight rows each.
    localparam logic [3:0] GLYPH [12][8] = '{
        '{4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6, 4'h0},
        '{4'h2, 4'h6, 4'h2, 4'h2, 4'h2, 4'h2, 4'h7, 4'h0},
        '{4'h6, 4'h9, 4'h1, 4'h2, 4'h4, 4'h4, 4'hF, 4'h0},
        '{4'h6, 4'h9, 4'h1, 4'h6, 4'h1, 4'h9, 4'h6, 4'h0},
        '{4'h1, 4'h3, 4'h5, 4'h9, 4'hF, 4'h1, 4'h1, 4'h0},
        '{4'hF, 4'h8, 4'hE, 4'h1, 4'h1, 4'h9, 4'h6, 4'h0},
        '{4'h6, 4'h8, 4'h8, 4'h6, 4'h9, 4'h9, 4'h6, 4'h0},
        '{4'hF, 4'h1, 4'h1, 4'h2, 4'h4, 4'h8, 4'h8, 4'h0},
        '{4'h6, 4'h9, 4'h9, 4'h6, 4'h9, 4'h9, 4'h6, 4'h0},
        '{4'h6, 4'h9, 4'h9, 4'h6, 4'h1, 4'h1, 4'h6, 4'h0},
        '{4'h0, 4'h0, 4'h2, 4'h0, 4'h0, 4'h2, 4'h0, 4'h0},
        '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1}
    };

    // Build one 32-bit row, leading zeros blanked, colon only after a digit.
    function automatic logic [31:0] render_row(logic [BCD_W-1:0] bcd, logic [2:0] row);
        logic [31:0] acc;
        logic [3:0]  dig;
        acc = '0;
        for (int p = 5; p >= 0; p--) begin
            dig = bcd[p*4 +: 4];
            if (dig < 4'd10 && (dig != 4'd0 || acc != '0)) begin
                acc = acc | {28'd0, GLYPH[dig][row]};
            end
            case (p)
                5: begin
                    acc = acc << 3;
                    if (acc != '0) begin
                        acc = acc | {28'd0, GLYPH[COLON][row]};
                    end
                    acc = acc << 4;
                end
                3: begin
                    acc = acc << 2;
                    acc = acc | {28'd0, GLYPH[DOT][row]};
                    acc = acc << 4;
                end
                0: begin
                    acc = acc;
                end
                default: begin
                    acc = acc << 5;
                end
            endcase
        end
        return acc;
    endfunction

    logic [IDX_W-1:0] row_idx;
    logic [2:0]       row;
    logic [1:0]       slot;
    logic [31:0]      bits;
    logic [7:0]       row_byte;
    logic [7:0]       addr;

    assign row_idx = req.idx - ROW_START;
    assign row     = row_idx[4:2];
    assign slot    = req.idx[1:0];
    assign bits    = render_row(req.bcd, row);
    assign addr    = {5'd0, row} + 8'd1;

    // Device slot zero carries the most significant row byte.
    always_comb begin
        case (slot)
            2'd0:    row_byte = bits[31:24];
            2'd1:    row_byte = bits[23:16];
            2'd2:    row_byte = bits[15:8];
            default: row_byte = bits[7:0];
        endcase
    end

    // Init words first, each command repeated for the four devices.
    always_comb begin
        if (req.idx < ROW_START) begin
            case (req.idx[3:2])
                2'd0:    res.spi_word = CMD_SHUTDOWN;
                2'd1:    res.spi_word = CMD_DECODE;
                2'd2:    res.spi_word = CMD_SCANLIM;
                default: res.spi_word = CMD_INTENS | {12'd0, brightness};
            endcase
        end else begin
            res.spi_word = {addr, row_byte};
        end
        res.latch = (slot == 2'd3);
        res.last  = (req.idx == LAST_IDX);
    end

endmodule

`default_nettype wire

@@ rtl/core/lmtr_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED matrix time renderer control
// Holds the current item, steps the word index and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_matrix_time_renderer_assert.svh"

module lmtr_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lmtr_pkg::BCD_W-1:0]        s_bcd,
    output lmtr_pkg::word_req_t                    req,
    input  wire lmtr_pkg::word_res_t               res,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output lmtr_pkg::word_res_t                    m_res
);
    import lmtr_pkg::*;

    logic             item_valid_reg, item_valid_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             init_sent_reg, init_sent_next;
    logic             out_valid_reg, out_valid_next;
    word_res_t        out_reg, out_next;

    logic out_free;
    logic load;
    logic load_last;
    logic accept;

    // A word moves into the output register whenever it is empty or draining.
    assign out_free  = !out_valid_reg || m_tready;
    assign load      = item_valid_reg && out_free;
    assign load_last = load && res.last;
    assign s_tready  = !item_valid_reg || load_last;
    assign accept    = s_tvalid && s_tready;

    assign req.bcd = bcd_reg;
    assign req.idx = idx_reg;

    // Item register and word index.
    always_comb begin
        item_valid_next = item_valid_reg;
        bcd_next        = bcd_reg;
        idx_next        = idx_reg;
        init_sent_next  = init_sent_reg;
        if (accept) begin
            item_valid_next = 1'b1;
            bcd_next        = s_bcd;
            idx_next        = init_sent_reg ? ROW_START : FIRST_IDX;
            init_sent_next  = 1'b1;
        end else if (load_last) begin
            item_valid_next = 1'b0;
        end else if (load) begin
            idx_next = idx_reg + 6'd1;
        end
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            init_sent_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            init_sent_reg  <= init_sent_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    // The final word of an item shows up as a marked output transaction.
    `LMTR_ASSERT_NEXT(a_last_reaches_out, aclk, aresetn, load_last, m_tvalid && m_res.last)
    // The first item after reset starts with the init words.
    `LMTR_ASSERT_NEXT(a_init_first, aclk, aresetn, accept && !init_sent_reg, idx_reg == FIRST_IDX)
    // Once sent, the init words are never sent again until reset.
    `LMTR_ASSERT_NEXT(a_init_sticky, aclk, aresetn, init_sent_reg, init_sent_reg)
    // A busy item register only takes a new item as its last word leaves.
    `LMTR_ASSERT_NOW(a_ready_when_busy, aclk, aresetn, s_tready && item_valid_reg, load_last)

endmodule

`default_nettype wire

@@ rtl/core/led_matrix_time_renderer.sv @@
// ----------------------------------------------------------------------------
// LED matrix time renderer
// Turns a six-digit BCD time into the word stream for four cascaded matrices.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[23:0] time_bcd
//  m_axis    out        tdata[15:0] spi_word, tuser latch, tlast last
//  apb       in/out     register 0: brightness[3:0]
//
//  One output word leaves per cycle unless the output stalls; an item is
//  32 words, 48 for the first after reset, walked by the index counter.
//  A new time is taken in the cycle its predecessor's last word is moved
//  into the output register, so there is no gap between items.
//  Reset is synchronous and active low; brightness resets to 7.
//  A stall on the output side holds the output register and the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_time_renderer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: time_bcd[23:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lmtr_pkg::BCD_W-1:0]        s_tdata,
    // tdata: spi_word[15:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [lmtr_pkg::WORD_W-1:0]       m_tdata,
    // tuser: latch[0]
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lmtr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [lmtr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [lmtr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import lmtr_pkg::*;

    logic [BRIGHT_W-1:0] brightness;
    word_req_t           req;
    word_res_t           res;
    word_res_t           m_res;

    lmtr_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .brightness (brightness)
    );

    lmtr_word_gen u_word_gen (
        .req        (req),
        .brightness (brightness),
        .res        (res)
    );

    lmtr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_bcd    (s_tdata),
        .req      (req),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.spi_word;
    assign m_tuser = m_res.latch;
    assign m_tlast = m_res.last;

endmodule

`default_nettype wire
